// File: src/scpw_pkg.sv
package scpw_pkg;

   localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

   localparam logic [1:0] REQ_ACCESS = 2'd0;
   localparam logic [1:0] REQ_DIR    = 2'd1;
   localparam logic [1:0] REQ_TBL    = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_EXEC  = 2'd2;
   localparam logic [1:0] KIND_ALIAS = 2'd3;

   localparam logic [1:0] RES_REQ   = 2'd0;
   localparam logic [1:0] RES_ADDR  = 2'd1;
   localparam logic [1:0] RES_FAULT = 2'd2;

   localparam logic [1:0] FK_NONE = 2'd0;
   localparam logic [1:0] FK_GP   = 2'd1;
   localparam logic [1:0] FK_SS   = 2'd2;
   localparam logic [1:0] FK_PF   = 2'd3;

   localparam logic CSR_PAGING_ENABLE  = 1'b0;
   localparam logic CSR_PAGE_DIR_FRAME = 1'b1;

   localparam logic [11:0] PAGE_MASK_LOW = 12'hfff;
   localparam logic [31:0] UPPER_SMALL   = 32'h0000_ffff;
   localparam logic [31:0] UPPER_BIG     = 32'hffff_ffff;

   // word carries the linear address for an access, the entry for a reply
   typedef struct packed {
      logic [1:0]  req_type;
      logic [1:0]  seg_fault;
      logic [1:0]  kind;
      logic [1:0]  cpl;
      logic [31:0] word;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] address;
      logic [1:0]  fault_kind;
      logic [2:0]  error_code;
      logic [31:0] fault_address;
   } rsp_type;

   typedef struct packed {
      logic        paging_enable;
      logic [19:0] page_dir_frame;
   } cfg_type;

endpackage

// File: src/scpw_fifo.sv
module scpw_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = scpw_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/scpw_front.sv
module scpw_front (
   input  logic              push,
   input  logic              cmd_full,
   input  logic [1:0]        req_type,
   input  logic [1:0]        req_access_kind,
   input  logic [31:0]       req_offset,
   input  logic [31:0]       req_seg_base,
   input  logic [19:0]       req_seg_limit,
   input  logic [15:0]       req_seg_attrs,
   input  logic [1:0]        req_selector_rpl,
   input  logic              req_is_stack_segment,
   input  logic [1:0]        req_current_privilege,
   input  logic [31:0]       req_mem_data,
   output logic              cmd_push,
   output scpw_pkg::cmd_type cmd_data
);

   logic        sbit, exec, rw, bit2, big, gran;
   logic [1:0]  dpl, kind;
   logic [31:0] eff_limit, upper;
   logic        type_fail, lim_fail, priv_fail;
   logic [1:0]  seg_fault;

   assign sbit = req_seg_attrs[4];
   assign exec = req_seg_attrs[3];
   assign bit2 = req_seg_attrs[2];
   assign rw   = req_seg_attrs[1];
   assign big  = req_seg_attrs[14];
   assign gran = req_seg_attrs[15];
   assign dpl  = req_seg_attrs[6:5];

   assign kind = (req_access_kind == scpw_pkg::KIND_ALIAS) ? scpw_pkg::KIND_READ
                                                          : req_access_kind;

   assign eff_limit = gran ? {req_seg_limit, scpw_pkg::PAGE_MASK_LOW}
                           : {12'd0, req_seg_limit};
   assign upper = big ? scpw_pkg::UPPER_BIG : scpw_pkg::UPPER_SMALL;

   always_comb begin
      if (exec) begin
         type_fail = (kind == scpw_pkg::KIND_WRITE) ||
                     ((kind == scpw_pkg::KIND_READ) && !rw);
      end else begin
         type_fail = (kind == scpw_pkg::KIND_EXEC) ||
                     ((kind == scpw_pkg::KIND_WRITE) && !rw);
      end
      // expand-down data segment
      if (!exec && bit2) begin
         lim_fail = !((req_offset > eff_limit) && (req_offset <= upper));
      end else begin
         lim_fail = (req_offset > eff_limit);
      end
      // conforming code skips the privilege test
      priv_fail = !(exec && bit2) &&
                  ((dpl < req_current_privilege) || (dpl < req_selector_rpl));
      priority if (!sbit) begin
         seg_fault = scpw_pkg::FK_NONE;
      end else if (type_fail) begin
         seg_fault = scpw_pkg::FK_GP;
      end else if (lim_fail) begin
         seg_fault = req_is_stack_segment ? scpw_pkg::FK_SS : scpw_pkg::FK_GP;
      end else if (priv_fail) begin
         seg_fault = scpw_pkg::FK_GP;
      end else begin
         seg_fault = scpw_pkg::FK_NONE;
      end
   end

   assign cmd_push = push && !cmd_full && (req_type != scpw_pkg::REQ_UNUSED);

   always_comb begin
      cmd_data.req_type  = req_type;
      cmd_data.seg_fault = seg_fault;
      cmd_data.kind      = kind;
      cmd_data.cpl       = req_current_privilege;
      cmd_data.word      = (req_type == scpw_pkg::REQ_ACCESS) ? req_seg_base + req_offset
                                                              : req_mem_data;
   end

endmodule

// File: src/scpw_back.sv
module scpw_back (
   input  logic              clock,
   input  logic              reset,
   input  scpw_pkg::cfg_type cfg,
   input  logic              cmd_empty,
   input  scpw_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output scpw_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DIR,
      PH_TBL
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pending_linear_ff, pending_linear_in;
   logic [1:0]  pending_kind_ff, pending_kind_in;
   logic [1:0]  pending_cpl_ff, pending_cpl_in;
   logic [31:0] dir_entry_ff, dir_entry_in;
   logic [31:0] last_fault_ff, last_fault_in;
   logic        fire, emit;
   logic        is_write, is_user, user_page, writable;
   logic [31:0] word;

   assign fire    = !cmd_empty && !rsp_full;
   assign cmd_pop = fire;
   assign word    = cmd_data.word;

   assign is_write  = (pending_kind_ff == scpw_pkg::KIND_WRITE);
   assign is_user   = (pending_cpl_ff == 2'd3);
   assign user_page = dir_entry_ff[2] && word[2];
   assign writable  = dir_entry_ff[1] && word[1];

   always_comb begin
      phase_in          = phase_ff;
      pending_linear_in = pending_linear_ff;
      pending_kind_in   = pending_kind_ff;
      pending_cpl_in    = pending_cpl_ff;
      dir_entry_in      = dir_entry_ff;
      last_fault_in     = last_fault_ff;
      emit              = 1'b0;
      rsp_data.result_kind   = scpw_pkg::RES_FAULT;
      rsp_data.address       = '0;
      rsp_data.fault_kind    = scpw_pkg::FK_NONE;
      rsp_data.error_code    = '0;
      rsp_data.fault_address = last_fault_ff;
      if (fire) begin
         priority if (cmd_data.req_type == scpw_pkg::REQ_ACCESS) begin
            emit     = 1'b1;
            phase_in = PH_IDLE;
            priority if (cmd_data.seg_fault != scpw_pkg::FK_NONE) begin
               rsp_data.fault_kind = cmd_data.seg_fault;
            end else if (!cfg.paging_enable) begin
               rsp_data.result_kind = scpw_pkg::RES_ADDR;
               rsp_data.address     = word;
            end else begin
               pending_linear_in    = word;
               pending_kind_in      = cmd_data.kind;
               pending_cpl_in       = cmd_data.cpl;
               phase_in             = PH_DIR;
               rsp_data.result_kind = scpw_pkg::RES_REQ;
               rsp_data.address     = {cfg.page_dir_frame, word[31:22], 2'b00};
            end
         end else if ((cmd_data.req_type == scpw_pkg::REQ_DIR) && (phase_ff == PH_DIR)) begin
            emit         = 1'b1;
            dir_entry_in = word;
            if (!word[0]) begin
               last_fault_in          = pending_linear_ff;
               phase_in               = PH_IDLE;
               rsp_data.fault_kind    = scpw_pkg::FK_PF;
               rsp_data.error_code    = {is_user, is_write, 1'b0};
               rsp_data.fault_address = pending_linear_ff;
            end else begin
               phase_in             = PH_TBL;
               rsp_data.result_kind = scpw_pkg::RES_REQ;
               rsp_data.address     = {word[31:12], pending_linear_ff[21:12], 2'b00};
            end
         end else if ((cmd_data.req_type == scpw_pkg::REQ_TBL) && (phase_ff == PH_TBL)) begin
            emit     = 1'b1;
            phase_in = PH_IDLE;
            priority if (!word[0] || !dir_entry_ff[0]) begin
               last_fault_in          = pending_linear_ff;
               rsp_data.fault_kind    = scpw_pkg::FK_PF;
               rsp_data.error_code    = {is_user, is_write, 1'b0};
               rsp_data.fault_address = pending_linear_ff;
            end else if (is_user && !user_page) begin
               last_fault_in          = pending_linear_ff;
               rsp_data.fault_kind    = scpw_pkg::FK_PF;
               rsp_data.error_code    = {1'b1, is_write, 1'b1};
               rsp_data.fault_address = pending_linear_ff;
            end else if (is_user && is_write && !writable) begin
               last_fault_in          = pending_linear_ff;
               rsp_data.fault_kind    = scpw_pkg::FK_PF;
               rsp_data.error_code    = 3'b111;
               rsp_data.fault_address = pending_linear_ff;
            end else begin
               rsp_data.result_kind = scpw_pkg::RES_ADDR;
               rsp_data.address     = {word[31:12], pending_linear_ff[11:0]};
            end
         end else begin
            emit = 1'b0;
         end
      end
   end

   assign rsp_push = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         pending_linear_ff <= '0;
         pending_kind_ff   <= '0;
         pending_cpl_ff    <= '0;
         dir_entry_ff      <= '0;
         last_fault_ff     <= '0;
      end else begin
         phase_ff          <= phase_in;
         pending_linear_ff <= pending_linear_in;
         pending_kind_ff   <= pending_kind_in;
         pending_cpl_ff    <= pending_cpl_in;
         dir_entry_ff      <= dir_entry_in;
         last_fault_ff     <= last_fault_in;
      end
   end

endmodule

// File: src/segment_check_and_page_walk_core.sv
// channel  | handshake          | beat
// req      | push / full        | one access request or page entry reply
// rsp      | pop / empty        | one read request, translated address or fault
// csr      | csr_we             | one register write, no wait
//
// one req beat is accepted per cycle while full is low; a result passes through the
// command queue and then the result queue before it shows on the rsp ports
// synchronous reset empties both queues, idles the page walk and clears the registers
// full rises while the command queue holds FIFO_DEPTH beats; the walk unit stalls
// only when the result queue is full
module segment_check_and_page_walk_core #(
   parameter int unsigned FIFO_DEPTH = scpw_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [1:0]  req_access_kind,
   input  logic [31:0] req_offset,
   input  logic [31:0] req_seg_base,
   input  logic [19:0] req_seg_limit,
   input  logic [15:0] req_seg_attrs,
   input  logic [1:0]  req_selector_rpl,
   input  logic        req_is_stack_segment,
   input  logic [1:0]  req_current_privilege,
   input  logic [31:0] req_mem_data,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_address,
   output logic [1:0]  rsp_fault_kind,
   output logic [2:0]  rsp_error_code,
   output logic [31:0] rsp_fault_address,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [19:0] csr_wdata
);

   localparam int unsigned CMD_W = $bits(scpw_pkg::cmd_type);
   localparam int unsigned RSP_W = $bits(scpw_pkg::rsp_type);

   scpw_pkg::cfg_type cfg_ff, cfg_in;
   scpw_pkg::cmd_type cmd_push_data, cmd_pop_data;
   scpw_pkg::rsp_type rsp_push_data, rsp_pop_data;
   logic              cmd_push, cmd_pop, cmd_empty;
   logic              rsp_push, rsp_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            scpw_pkg::CSR_PAGING_ENABLE:  cfg_in.paging_enable  = csr_wdata[0];
            scpw_pkg::CSR_PAGE_DIR_FRAME: cfg_in.page_dir_frame = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scpw_front u_front (
      .push                  (push),
      .cmd_full              (full),
      .req_type              (req_type),
      .req_access_kind       (req_access_kind),
      .req_offset            (req_offset),
      .req_seg_base          (req_seg_base),
      .req_seg_limit         (req_seg_limit),
      .req_seg_attrs         (req_seg_attrs),
      .req_selector_rpl      (req_selector_rpl),
      .req_is_stack_segment  (req_is_stack_segment),
      .req_current_privilege (req_current_privilege),
      .req_mem_data          (req_mem_data),
      .cmd_push              (cmd_push),
      .cmd_data              (cmd_push_data)
   );

   scpw_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .empty     (cmd_empty)
   );

   scpw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_pop_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_push_data)
   );

   scpw_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_pop_data),
      .empty     (empty)
   );

   assign rsp_result_kind   = rsp_pop_data.result_kind;
   assign rsp_address       = rsp_pop_data.address;
   assign rsp_fault_kind    = rsp_pop_data.fault_kind;
   assign rsp_error_code    = rsp_pop_data.error_code;
   assign rsp_fault_address = rsp_pop_data.fault_address;

   a_fault_has_kind : assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_result_kind == scpw_pkg::RES_FAULT)) |->
         (rsp_fault_kind != scpw_pkg::FK_NONE))
      else $error("fault beat without fault kind");

   a_clean_beat : assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_result_kind != scpw_pkg::RES_FAULT)) |->
         ((rsp_fault_kind == scpw_pkg::FK_NONE) && (rsp_error_code == 3'd0)))
      else $error("non-fault beat carries fault bits");

   a_error_only_pf : assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_error_code != 3'd0)) |-> (rsp_fault_kind == scpw_pkg::FK_PF))
      else $error("error code outside page fault");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

endmodule
